// ----- sv/assert_macros.svh -----
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FGBE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FGBE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/fgbe_pkg.sv -----
package fgbe_pkg;

	localparam int ANGLE_W = 32;
	localparam int TIME_W  = 22;
	localparam int BIAS_W  = 22;
	localparam int LIM_W   = 21;
	localparam int GAIN_W  = 17;
	localparam int STAT_W  = 2;
	localparam int AXES    = 3;
	localparam int AXIS_W  = 2;

	localparam int SCALE_W = 20;
	localparam logic [SCALE_W-1:0] RATE_SCALE = 20'd1000000;

	// |angle| * 1e6 < 2^51
	localparam int MAG_W   = 51;
	localparam int DVD_W   = 52;
	localparam int RATE_W  = 52;
	localparam int DIFF_W  = RATE_W + 1;
	localparam int ERR_W   = BIAS_W + 1;
	localparam int PROD_W  = ERR_W + GAIN_W + 1;
	localparam int ACC_W   = PROD_W + 1;
	localparam int STEP_W  = ACC_W - 16;
	localparam int NB_W    = STEP_W + 1;

	localparam int DIV_STEPS = 2;
	localparam int DIV_ITER  = DVD_W / DIV_STEPS;
	localparam int DIV_CNT_W = $clog2(DIV_ITER + 1);

	localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

	localparam int S_TDATA_W = 240;
	localparam int M_TDATA_W = 72;

	localparam int APB_DW = 32;
	localparam int APB_AW = 5;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_MAX_INTERVAL = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAX_MISMATCH = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MIN_INTERVAL = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SPIKE_LIMIT  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_FILTER_GAIN  = 3'd4;

	typedef logic [STAT_W-1:0] status_t;
	localparam status_t STATUS_RESET   = 2'd0;
	localparam status_t STATUS_UPDATED = 2'd1;
	localparam status_t STATUS_SKIPPED = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0] max_interval_us;
		logic [TIME_W-1:0] max_mismatch_us;
		logic [TIME_W-1:0] min_interval_us;
		logic [LIM_W-1:0]  spike_limit;
		logic [GAIN_W-1:0] filter_gain;
	} cfg_t;

endpackage

// ----- sv/fgbe_regs.sv -----
module fgbe_regs
	import fgbe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;

	assign idx    = paddr[APB_AW-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_interval_us <= 22'd1000000;
			cfg_q.max_mismatch_us <= 22'd100000;
			cfg_q.min_interval_us <= 22'd10000;
			cfg_q.spike_limit     <= 21'd1677722;
			cfg_q.filter_gain     <= 17'd655;
		end else if (wr_en) begin
			case (idx)
				REG_MAX_INTERVAL: cfg_q.max_interval_us <= pwdata[TIME_W-1:0];
				REG_MAX_MISMATCH: cfg_q.max_mismatch_us <= pwdata[TIME_W-1:0];
				REG_MIN_INTERVAL: cfg_q.min_interval_us <= pwdata[TIME_W-1:0];
				REG_SPIKE_LIMIT:  cfg_q.spike_limit     <= pwdata[LIM_W-1:0];
				REG_FILTER_GAIN:  cfg_q.filter_gain     <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MAX_INTERVAL: prdata = APB_DW'(cfg_q.max_interval_us);
			REG_MAX_MISMATCH: prdata = APB_DW'(cfg_q.max_mismatch_us);
			REG_MIN_INTERVAL: prdata = APB_DW'(cfg_q.min_interval_us);
			REG_SPIKE_LIMIT:  prdata = APB_DW'(cfg_q.spike_limit);
			REG_FILTER_GAIN:  prdata = APB_DW'(cfg_q.filter_gain);
			default:          prdata = '0;
		endcase
	end

endmodule

// ----- sv/fgbe_div.sv -----
module fgbe_div
	import fgbe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DVD_W-1:0]  dividend,
	input  logic [TIME_W-1:0] divisor,
	output logic              busy,
	output logic              done,
	output logic [DVD_W-1:0]  quotient
);

	logic [TIME_W-1:0]    rem_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [TIME_W-1:0]    dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [TIME_W-1:0] rem_n;
	logic [DVD_W-1:0]  dvd_n;
	logic [TIME_W:0]   trial;

	// restoring division, two quotient bits per cycle
	always_comb begin
		rem_n = rem_q;
		dvd_n = dvd_q;
		trial = '0;
		for (int k = 0; k < DIV_STEPS; k++) begin
			trial = {rem_n, dvd_n[DVD_W-1]};
			if (trial >= {1'b0, dsr_q}) begin
				trial = trial - {1'b0, dsr_q};
				dvd_n = {dvd_n[DVD_W-2:0], 1'b1};
			end else begin
				dvd_n = {dvd_n[DVD_W-2:0], 1'b0};
			end
			rem_n = trial[TIME_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_ITER);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			dvd_q <= dvd_n;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ----- sv/flow_gyro_bias_estimator.sv -----
// Optical-flow gyro bias estimator. Each input beat carries the IMU delta angle and interval and
// the flow sensor's integrated gyro angle and interval; each beat gives exactly one output beat
// with the three bias values after the step and a status (0 interval too long, 1 updated,
// 2 skipped). A reset or skipped beat goes from accept straight to output. For an updating beat,
// every axis needs two angle*1e6/interval divisions on the one shared divider, which retires two
// quotient bits per cycle, each division passing through operand setup (ST_MUL), start (ST_DIVGO)
// and wait (ST_DIV), then the filter steps ST_DIFF, ST_SCALE and ST_WB for that axis.
// s_tready is high only while no beat is in work; a finished result waits in the output register.
`include "assert_macros.svh"

module flow_gyro_bias_estimator
	import fgbe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// imu_angle_x, imu_angle_y, imu_angle_z, imu_interval_us,
	// flow_angle_x, flow_angle_y, flow_angle_z, flow_interval_us
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// bias_x, bias_y, bias_z
	output logic [M_TDATA_W-1:0] m_tdata,
	// step_status
	output logic [STAT_W-1:0]    m_tuser,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [APB_AW-1:0]    paddr,
	input  logic [APB_DW-1:0]    pwdata,
	output logic [APB_DW-1:0]    prdata,
	output logic                 pready
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MUL   = 7'b0000010,
		ST_DIVGO = 7'b0000100,
		ST_DIV   = 7'b0001000,
		ST_DIFF  = 7'b0010000,
		ST_SCALE = 7'b0100000,
		ST_WB    = 7'b1000000
	} state_t;

	localparam logic signed [NB_W-1:0] NB_MAX = NB_W'(2097151);
	localparam logic signed [NB_W-1:0] NB_MIN = -NB_W'(2097152);

	cfg_t cfg;

	fgbe_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	state_t state_q;
	logic   out_pend_q;

	logic [ANGLE_W-1:0] imu_ang_q [AXES];
	logic [ANGLE_W-1:0] flow_ang_q [AXES];
	logic [TIME_W-1:0]  imu_dt_q;
	logic [TIME_W-1:0]  flow_dt_q;
	status_t            status_q;
	logic [AXIS_W-1:0]  axis_q;
	logic               phase_q;
	logic               neg_q;
	logic [MAG_W-1:0]   prod_q;
	logic signed [RATE_W-1:0] ref_rate_q;
	logic signed [RATE_W-1:0] flow_rate_q;
	logic signed [BIAS_W-1:0] dclamp_q;
	logic signed [PROD_W-1:0] scaled_q;
	logic signed [BIAS_W-1:0] bias_q [AXES];

	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	status_t              m_tuser_q;

	logic [TIME_W-1:0] in_imu_dt;
	logic [TIME_W-1:0] in_flow_dt;
	logic [TIME_W-1:0] dt_diff;
	status_t           in_status;
	logic              accept;
	logic              out_free;

	logic [ANGLE_W-1:0] ang_sel;
	logic [ANGLE_W-1:0] ang_mag;
	logic [MAG_W-1:0]   prod_c;

	logic              div_start;
	logic              div_busy;
	logic              div_done;
	logic [DVD_W-1:0]  div_quot;
	logic [TIME_W-1:0] div_dsr;
	logic signed [RATE_W-1:0] rate_c;

	logic signed [DIFF_W-1:0] diff_c;
	logic signed [DIFF_W-1:0] lim_c;
	logic signed [BIAS_W-1:0] clamp_c;
	logic signed [BIAS_W-1:0] bias_sel;
	logic signed [ERR_W-1:0]  err_c;
	logic [GAIN_W-1:0]        gain_eff;
	logic signed [GAIN_W:0]   gain_s;
	logic signed [ACC_W-1:0]  acc_c;
	logic signed [STEP_W-1:0] step_c;
	logic signed [NB_W-1:0]   nb_c;
	logic signed [BIAS_W-1:0] nb_sat;
	logic [AXES*BIAS_W-1:0]   bias_all;

	// beat decode and step classification
	assign in_imu_dt  = s_tdata[117:96];
	assign in_flow_dt = s_tdata[235:214];
	assign dt_diff    = (in_imu_dt > in_flow_dt) ? in_imu_dt - in_flow_dt
	                                             : in_flow_dt - in_imu_dt;

	always_comb begin
		if (in_imu_dt > cfg.max_interval_us) begin
			in_status = STATUS_RESET;
		end else if (dt_diff < cfg.max_mismatch_us && in_imu_dt > cfg.min_interval_us
		             && in_flow_dt != '0) begin
			in_status = STATUS_UPDATED;
		end else begin
			in_status = STATUS_SKIPPED;
		end
	end

	assign s_tready = (state_q == ST_IDLE) && !out_pend_q;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// rate numerator magnitude
	assign ang_sel = phase_q ? flow_ang_q[axis_q] : imu_ang_q[axis_q];
	assign ang_mag = ang_sel[ANGLE_W-1] ? (~ang_sel + 1'b1) : ang_sel;
	assign prod_c  = MAG_W'(ang_mag) * MAG_W'(RATE_SCALE);

	assign div_start = (state_q == ST_DIVGO);
	assign div_dsr   = phase_q ? flow_dt_q : imu_dt_q;

	fgbe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({1'b0, prod_q}),
		.divisor  (div_dsr),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	// truncation toward zero: divide magnitudes, then restore the sign
	assign rate_c = neg_q ? -$signed(div_quot) : $signed(div_quot);

	// spike clamp
	assign diff_c = DIFF_W'(flow_rate_q) - DIFF_W'(ref_rate_q);
	assign lim_c  = $signed({{(DIFF_W-LIM_W){1'b0}}, cfg.spike_limit});

	always_comb begin
		if (diff_c > lim_c) begin
			clamp_c = lim_c[BIAS_W-1:0];
		end else if (diff_c < -lim_c) begin
			clamp_c = BIAS_W'(-lim_c);
		end else begin
			clamp_c = diff_c[BIAS_W-1:0];
		end
	end

	// low-pass filter, round half up
	assign bias_sel = bias_q[axis_q];
	assign err_c    = ERR_W'(dclamp_q) - ERR_W'(bias_sel);
	assign gain_eff = (cfg.filter_gain > GAIN_ONE) ? GAIN_ONE : cfg.filter_gain;
	assign gain_s   = $signed({1'b0, gain_eff});
	assign acc_c    = ACC_W'(scaled_q) + ACC_W'(32768);
	assign step_c   = acc_c[ACC_W-1:16];
	assign nb_c     = NB_W'(bias_sel) + NB_W'(step_c);

	always_comb begin
		if (nb_c > NB_MAX) begin
			nb_sat = NB_MAX[BIAS_W-1:0];
		end else if (nb_c < NB_MIN) begin
			nb_sat = NB_MIN[BIAS_W-1:0];
		end else begin
			nb_sat = nb_c[BIAS_W-1:0];
		end
	end

	assign bias_all = {bias_q[2], bias_q[1], bias_q[0]};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			out_pend_q <= 1'b0;
			axis_q     <= '0;
			phase_q    <= 1'b0;
			status_q   <= STATUS_SKIPPED;
			for (int i = 0; i < AXES; i++) begin
				bias_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						status_q <= in_status;
						axis_q   <= '0;
						phase_q  <= 1'b0;
						if (in_status == STATUS_UPDATED) begin
							state_q <= ST_MUL;
						end else begin
							out_pend_q <= 1'b1;
						end
					end
				end
				ST_MUL:   state_q <= ST_DIVGO;
				ST_DIVGO: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						if (!phase_q) begin
							phase_q <= 1'b1;
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_DIFF;
						end
					end
				end
				ST_DIFF:  state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_WB;
				ST_WB: begin
					bias_q[axis_q] <= nb_sat;
					phase_q        <= 1'b0;
					if (axis_q == AXIS_W'(AXES - 1)) begin
						state_q    <= ST_IDLE;
						out_pend_q <= 1'b1;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_pend_q && out_free) begin
				out_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			imu_ang_q[0]  <= s_tdata[31:0];
			imu_ang_q[1]  <= s_tdata[63:32];
			imu_ang_q[2]  <= s_tdata[95:64];
			imu_dt_q      <= in_imu_dt;
			flow_ang_q[0] <= s_tdata[149:118];
			flow_ang_q[1] <= s_tdata[181:150];
			flow_ang_q[2] <= s_tdata[213:182];
			flow_dt_q     <= in_flow_dt;
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_c;
			neg_q  <= ang_sel[ANGLE_W-1];
		end
		if (state_q == ST_DIV && div_done) begin
			if (phase_q) begin
				flow_rate_q <= rate_c;
			end else begin
				ref_rate_q <= rate_c;
			end
		end
		if (state_q == ST_DIFF) begin
			dclamp_q <= clamp_c;
		end
		if (state_q == ST_SCALE) begin
			scaled_q <= err_c * gain_s;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_pend_q && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_pend_q && out_free) begin
			m_tdata_q <= M_TDATA_W'(bias_all);
			m_tuser_q <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`FGBE_ASSERT_IMPL(a_div_idle_start, div_start, !div_busy,
		"divider restarted while busy")
	`FGBE_ASSERT_IMPL(a_div_done_state, div_done, state_q == ST_DIV,
		"divider finished outside the wait state")
	`FGBE_ASSERT_NEXT(a_bias_hold, state_q != ST_WB, $stable(bias_all),
		"bias changed outside write-back")
	`FGBE_ASSERT_IMPL(a_upd_only_math, state_q == ST_DIV || state_q == ST_WB,
		status_q == STATUS_UPDATED, "arithmetic ran for a non-updating beat")

endmodule
